### src/sfp_pkg.sv
package sfp_pkg;

    localparam int DIM_W    = 13;
    localparam int POS_X_W  = 12;
    localparam int POS_Y_W  = 18;
    localparam int STATUS_W = 3;
    localparam int HGT_W    = 19;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OLD_SHELF = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW_SHELF = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_WIDE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    typedef struct packed {
        logic [DIM_W-1:0] used;
        logic [DIM_W-1:0] height;
    } shelf_t;

    typedef struct packed {
        logic [POS_X_W-1:0]  pos_x;
        logic [POS_Y_W-1:0]  pos_y;
        logic [STATUS_W-1:0] status;
        logic [HGT_W-1:0]    sheet_height;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

endpackage

### src/sfp_in_if.sv
interface sfp_in_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [sfp_pkg::DIM_W-1:0] rect_width;
    logic [sfp_pkg::DIM_W-1:0] rect_height;

    modport source (output valid, output op, output rect_width, output rect_height,
                    input ready);
    modport sink   (input valid, input op, input rect_width, input rect_height,
                    output ready);
endinterface

### src/sfp_out_if.sv
interface sfp_out_if;
    logic                         valid;
    logic                         ready;
    logic [sfp_pkg::POS_X_W-1:0]  pos_x;
    logic [sfp_pkg::POS_Y_W-1:0]  pos_y;
    logic [sfp_pkg::STATUS_W-1:0] status;
    logic [sfp_pkg::HGT_W-1:0]    sheet_height;

    modport source (output valid, output pos_x, output pos_y, output status,
                    output sheet_height, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input status,
                    input sheet_height, output ready);
endinterface

### src/sfp_ram.sv
module sfp_ram #(
    parameter int WIDTH  = 26,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/sfp_out_stage.sv
module sfp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfp_pkg::push_t       push,
    output logic                 slot_free,
    sfp_out_if.source            out_ch
);

    logic                     valid_reg;
    logic                     valid_next;
    sfp_pkg::result_t         data_reg;
    sfp_pkg::result_t         data_next;

    assign slot_free = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (push.valid && slot_free)
        begin
            valid_next = 1'b1;
            data_next  = push.res;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            data_reg  <= data_next;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.pos_x        = data_reg.pos_x;
    assign out_ch.pos_y        = data_reg.pos_y;
    assign out_ch.status       = data_reg.status;
    assign out_ch.sheet_height = data_reg.sheet_height;

endmodule

### src/sfp_ctrl.sv
module sfp_ctrl #(
    parameter int MAX_SHELVES = 64,
    parameter int MAX_DIM     = 4096,
    parameter int IDX_W       = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    sfp_in_if.sink                    in_ch,
    input  logic                      cfg_wr_en,
    input  logic [sfp_pkg::DIM_W-1:0] cfg_wr_data,
    output logic                      ram_re,
    output logic [IDX_W-1:0]          ram_raddr,
    input  sfp_pkg::shelf_t           ram_rdata,
    output logic                      ram_we,
    output logic [IDX_W-1:0]          ram_waddr,
    output sfp_pkg::shelf_t           ram_wdata,
    output sfp_pkg::push_t            push,
    input  logic                      slot_free
);

    localparam int CNT_W = $clog2(MAX_SHELVES + 1);
    localparam int DW    = sfp_pkg::DIM_W;
    localparam int YW    = sfp_pkg::POS_Y_W;
    localparam int HW    = sfp_pkg::HGT_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUSH} state_t;

    state_t                state_reg,       state_next;
    logic [DW-1:0]         sheet_width_reg, sheet_width_next;
    logic [CNT_W-1:0]      count_reg,       count_next;
    logic [HW-1:0]         total_reg,       total_next;
    logic [DW-1:0]         w_reg,           w_next;
    logic [DW-1:0]         h_reg,           h_next;
    logic [CNT_W-1:0]      rd_idx_reg,      rd_idx_next;
    logic                  chk_valid_reg,   chk_valid_next;
    logic [IDX_W-1:0]      chk_idx_reg,     chk_idx_next;
    logic [YW-1:0]         y_reg,           y_next;
    sfp_pkg::result_t      res_reg,         res_next;

    logic [DW-1:0]         eff_width;
    logic                  too_wide;
    logic                  issue;
    logic [DW:0]           used_sum;
    logic                  fit;

    always_comb
    begin
        if (32'(sheet_width_reg) > MAX_DIM)
        begin
            eff_width = DW'(MAX_DIM);
        end
        else
        begin
            eff_width = sheet_width_reg;
        end
    end

    assign too_wide = (in_ch.rect_width == '0) || (in_ch.rect_width > eff_width)
                      || (32'(in_ch.rect_height) > MAX_DIM);

    assign issue    = rd_idx_reg < count_reg;
    assign used_sum = {1'b0, ram_rdata.used} + {1'b0, w_reg};
    assign fit      = chk_valid_reg && (ram_rdata.height >= h_reg)
                      && (used_sum <= {1'b0, eff_width});

    assign in_ch.ready = (state_reg == S_IDLE);
    assign ram_re      = (state_reg == S_SCAN) && issue;
    assign ram_raddr   = rd_idx_reg[IDX_W-1:0];
    assign push.valid  = (state_reg == S_PUSH);
    assign push.res    = res_reg;

    always_comb
    begin
        state_next       = state_reg;
        sheet_width_next = cfg_wr_en ? cfg_wr_data : sheet_width_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        w_next           = w_reg;
        h_next           = h_reg;
        rd_idx_next      = rd_idx_reg;
        chk_valid_next   = chk_valid_reg;
        chk_idx_next     = chk_idx_reg;
        y_next           = y_reg;
        res_next         = res_reg;
        ram_we           = 1'b0;
        ram_waddr        = chk_idx_reg;
        ram_wdata        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    w_next         = in_ch.rect_width;
                    h_next         = in_ch.rect_height;
                    rd_idx_next    = '0;
                    chk_valid_next = 1'b0;
                    y_next         = '0;
                    if (in_ch.op == sfp_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                        total_next = '0;
                        res_next   = '{pos_x: '0, pos_y: '0, status: sfp_pkg::ST_CLEARED,
                                       sheet_height: '0};
                        state_next = S_PUSH;
                    end
                    else if (too_wide)
                    begin
                        res_next   = '{pos_x: '0, pos_y: '0, status: sfp_pkg::ST_TOO_WIDE,
                                       sheet_height: total_reg};
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // one shelf read issued and one shelf checked per cycle
                chk_valid_next = issue;
                chk_idx_next   = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (fit)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = chk_idx_reg;
                    ram_wdata  = '{used: used_sum[DW-1:0], height: ram_rdata.height};
                    res_next   = '{pos_x: ram_rdata.used[sfp_pkg::POS_X_W-1:0],
                                   pos_y: y_reg, status: sfp_pkg::ST_OLD_SHELF,
                                   sheet_height: total_reg};
                    state_next = S_PUSH;
                end
                else
                begin
                    if (chk_valid_reg)
                    begin
                        y_next = y_reg + YW'(ram_rdata.height);
                    end
                    if (!issue)
                    begin
                        if (count_reg == CNT_W'(MAX_SHELVES))
                        begin
                            res_next = '{pos_x: '0, pos_y: '0, status: sfp_pkg::ST_FULL,
                                         sheet_height: total_reg};
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            ram_wdata  = '{used: w_reg, height: h_reg};
                            count_next = count_reg + CNT_W'(1);
                            total_next = total_reg + HW'(h_reg);
                            res_next   = '{pos_x: '0, pos_y: total_reg[YW-1:0],
                                           status: sfp_pkg::ST_NEW_SHELF,
                                           sheet_height: total_reg + HW'(h_reg)};
                        end
                        state_next = S_PUSH;
                    end
                end
            end

            S_PUSH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sheet_width_reg <= DW'(1024);
            count_reg       <= '0;
            total_reg       <= '0;
            w_reg           <= '0;
            h_reg           <= '0;
            rd_idx_reg      <= '0;
            chk_valid_reg   <= 1'b0;
            chk_idx_reg     <= '0;
            y_reg           <= '0;
            res_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            sheet_width_reg <= sheet_width_next;
            count_reg       <= count_next;
            total_reg       <= total_next;
            w_reg           <= w_next;
            h_reg           <= h_next;
            rd_idx_reg      <= rd_idx_next;
            chk_valid_reg   <= chk_valid_next;
            chk_idx_reg     <= chk_idx_next;
            y_reg           <= y_next;
            res_reg         <= res_next;
        end
    end

endmodule

### src/shelf_first_fit_packer.sv
// Shelf first-fit rectangle packer.
//
// in_ch carries one request per beat: op selects place or clear, rect_width
// and rect_height give the rectangle. out_ch returns exactly one result beat
// per request: pos_x, pos_y, status and the sheet height after the request.
// cfg_wr_en / cfg_wr_data write the sheet width; write it only while idle.
//
// Timing: a place request reads the shelf table one shelf per cycle through
// the single read port of the shelf memory and stops on the first shelf that
// fits; a request that opens a new shelf or finds the table full reads every
// open shelf first. Clear and too-wide requests skip the scan. One request
// is worked on at a time; the next is taken the cycle after the result moves
// into the output register.
//
// Reset clears the shelf count, the total height and the output register and
// sets the sheet width to 1024. The shelf memory needs no clearing: only
// entries below the shelf count are read, and each was written on opening.
// When the receiver stalls, the result holds in the output register and a
// new request may still be accepted and scanned; it then waits for the slot.
module shelf_first_fit_packer #(
    parameter int MAX_SHELVES = 64,
    parameter int MAX_DIM     = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    sfp_in_if.sink                    in_ch,
    sfp_out_if.source                 out_ch,
    input  logic                      cfg_wr_en,
    input  logic [sfp_pkg::DIM_W-1:0] cfg_wr_data
);

    localparam int IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;

    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    sfp_pkg::shelf_t  ram_rdata;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    sfp_pkg::shelf_t  ram_wdata;
    sfp_pkg::push_t   push;
    logic             slot_free;

    // Shelf table: used width and height of each shelf in one word.
    sfp_ram #(
        .WIDTH  ($bits(sfp_pkg::shelf_t)),
        .DEPTH  (MAX_SHELVES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Scan sequencer: accept, read-check-update shelves, build the result.
    sfp_ctrl #(
        .MAX_SHELVES (MAX_SHELVES),
        .MAX_DIM     (MAX_DIM),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .push        (push),
        .slot_free   (slot_free)
    );

    // Output register: hold the result beat until the receiver takes it.
    sfp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .slot_free (slot_free),
        .out_ch    (out_ch)
    );

endmodule

### src/sfp_checker.sv
module sfp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [sfp_pkg::POS_X_W-1:0]  pos_x,
    input logic [sfp_pkg::POS_Y_W-1:0]  pos_y,
    input logic [sfp_pkg::STATUS_W-1:0] status,
    input logic [sfp_pkg::HGT_W-1:0]    sheet_height
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(status) && $stable(sheet_height))
        else $error("stalled result changed");

    // one request at a time: busy right after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sfp_pkg::ST_CLEARED
            |-> pos_x == '0 && pos_y == '0 && sheet_height == '0)
        else $error("clear result not zero");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sfp_pkg::ST_TOO_WIDE || status == sfp_pkg::ST_FULL)
            |-> pos_x == '0 && pos_y == '0)
        else $error("rejected request has a position");

    a_new_shelf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sfp_pkg::ST_NEW_SHELF |-> pos_x == '0)
        else $error("new shelf placement not at left edge");

endmodule

bind shelf_first_fit_packer sfp_checker u_sfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .pos_x        (out_ch.pos_x),
    .pos_y        (out_ch.pos_y),
    .status       (out_ch.status),
    .sheet_height (out_ch.sheet_height)
);

### tb/sfp_packing_checker.sv
`timescale 1ns / 100ps

module sfp_packing_checker #(
    parameter int MAX_SHELVES = 64,
    parameter int MAX_DIM     = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    sfp_in_if                         in_ch,
    sfp_out_if                        out_ch,
    input  logic                      cfg_wr_en,
    input  logic [sfp_pkg::DIM_W-1:0] cfg_wr_data,
    output int                        mismatch_count,
    output int                        results_due
);

    // Shadow copy of the shelf table and the sheet register.
    logic [sfp_pkg::DIM_W-1:0] shelf_used [MAX_SHELVES];
    logic [sfp_pkg::DIM_W-1:0] shelf_hgt  [MAX_SHELVES];
    int unsigned               open_shelves;
    logic [sfp_pkg::HGT_W-1:0] stack_height;
    logic [sfp_pkg::DIM_W-1:0] sheet_width;

    sfp_pkg::result_t          placement_q[$];
    int                        err_cnt = 0;
    int                        due_cnt = 0;

    assign mismatch_count = err_cnt;
    assign results_due    = due_cnt;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // Apply one request to the shadow table and return the result it must give.
    function automatic sfp_pkg::result_t place_or_clear(input logic op,
                                                        input logic [sfp_pkg::DIM_W-1:0] w,
                                                        input logic [sfp_pkg::DIM_W-1:0] h);
        sfp_pkg::result_t res;
        int unsigned      usable;
        int unsigned      top_y;
        res    = '0;
        usable = (sheet_width < MAX_DIM) ? sheet_width : MAX_DIM;
        if (op == sfp_pkg::OP_CLEAR)
        begin
            open_shelves = 0;
            stack_height = '0;
            res.status   = sfp_pkg::ST_CLEARED;
            return res;
        end
        res.sheet_height = stack_height;
        if (w == 0 || w > usable || h > MAX_DIM)
        begin
            res.status = sfp_pkg::ST_TOO_WIDE;
            return res;
        end
        top_y = 0;
        for (int k = 0; k < open_shelves; k++)
        begin
            if (shelf_hgt[k] >= h && shelf_used[k] + w <= usable)
            begin
                res.pos_x     = sfp_pkg::POS_X_W'(shelf_used[k]);
                res.pos_y     = sfp_pkg::POS_Y_W'(top_y);
                res.status    = sfp_pkg::ST_OLD_SHELF;
                shelf_used[k] = shelf_used[k] + w;
                return res;
            end
            top_y += shelf_hgt[k];
        end
        if (open_shelves >= MAX_SHELVES)
        begin
            res.status = sfp_pkg::ST_FULL;
            return res;
        end
        shelf_hgt[open_shelves]  = h;
        shelf_used[open_shelves] = w;
        open_shelves++;
        res.pos_y        = sfp_pkg::POS_Y_W'(stack_height);
        res.status       = sfp_pkg::ST_NEW_SHELF;
        stack_height     = stack_height + h;
        res.sheet_height = stack_height;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sfp_pkg::result_t want;
        if (!rst_n)
        begin
            open_shelves = 0;
            stack_height = '0;
            sheet_width  = sfp_pkg::DIM_W'(1024);
            placement_q.delete();
            due_cnt      = 0;
        end
        else
        begin
            // Retire the result beat before taking a new request beat.
            if (out_ch.valid && out_ch.ready)
            begin
                if (placement_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing pending, status",
                                    32'(out_ch.status), 0);
                end
                else
                begin
                    want = placement_q.pop_front();
                    if (out_ch.pos_x !== want.pos_x)
                        report_mismatch("pos_x", 32'(out_ch.pos_x), 32'(want.pos_x));
                    if (out_ch.pos_y !== want.pos_y)
                        report_mismatch("pos_y", 32'(out_ch.pos_y), 32'(want.pos_y));
                    if (out_ch.status !== want.status)
                        report_mismatch("status", 32'(out_ch.status), 32'(want.status));
                    if (out_ch.sheet_height !== want.sheet_height)
                        report_mismatch("sheet_height", 32'(out_ch.sheet_height),
                                        32'(want.sheet_height));
                end
            end
            if (in_ch.valid && in_ch.ready)
                placement_q.push_back(place_or_clear(in_ch.op, in_ch.rect_width,
                                                     in_ch.rect_height));
            if (cfg_wr_en)
                sheet_width = cfg_wr_data;
            due_cnt = placement_q.size();
        end
    end

endmodule

### tb/shelf_first_fit_packer_tb.sv
`timescale 1ns / 100ps

module shelf_first_fit_packer_tb;

    localparam int MAX_SHELVES  = 64;
    localparam int MAX_DIM      = 4096;
    localparam int RANDOM_REQS  = 750;
    // Worst case scan plus a margin; used for the quiet time at the end.
    localparam int DRAIN_CYCLES = MAX_SHELVES + 8;

    // Kinds of random request runs.
    typedef enum int {RUN_PACK, RUN_FILL, RUN_NOISE} run_kind_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [sfp_pkg::DIM_W-1:0] cfg_wr_data;
    int                        mismatch_count;
    int                        results_due;

    // Random gaps on both channels while set; cleared for back-to-back stretches.
    bit               gaps_on = 1'b1;
    int unsigned      random_reqs;
    // Sheet width as the block sees it, saturated at MAX_DIM.
    int unsigned      usable_width;

    sfp_in_if  req_ch ();
    sfp_out_if res_ch ();

    shelf_first_fit_packer #(
        .MAX_SHELVES (MAX_SHELVES),
        .MAX_DIM     (MAX_DIM)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (req_ch),
        .out_ch      (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // The checker watches both channels and the register port, predicts every
    // result and counts mismatches; this module only drives and judges.
    sfp_packing_checker #(
        .MAX_SHELVES (MAX_SHELVES),
        .MAX_DIM     (MAX_DIM)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (req_ch),
        .out_ch         (res_ch),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Hard stop: several times the slowest legal run, full scans on every beat
    // and the longest gaps and stalls on both sides included.
    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    // Drive one request beat. Hold valid from the previous beat when there is
    // no gap so it never drops and rises in the same step. Return at the
    // falling edge after acceptance.
    task automatic send_request(input logic op, input logic [sfp_pkg::DIM_W-1:0] w,
                                input logic [sfp_pkg::DIM_W-1:0] h);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.rect_width  <= w;
        req_ch.rect_height <= h;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic place(input int unsigned w, input int unsigned h);
        send_request(sfp_pkg::OP_PLACE, sfp_pkg::DIM_W'(w), sfp_pkg::DIM_W'(h));
    endtask

    // Fill the ignored size fields with noise on a clear.
    task automatic clear_sheet();
        send_request(sfp_pkg::OP_CLEAR, sfp_pkg::DIM_W'($urandom_range(0, 8191)),
                     sfp_pkg::DIM_W'($urandom_range(0, 8191)));
    endtask

    // Drop valid, wait until every predicted result has come back, then write
    // the sheet width in a single cycle.
    task automatic set_sheet_width(input int unsigned value);
        req_ch.valid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= sfp_pkg::DIM_W'(value);
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        usable_width = (value < MAX_DIM) ? value : MAX_DIM;
    endtask

    // Result side: draw a stall for every beat, then hold ready until it moves.
    initial
    begin
        int unsigned stall;
        res_ch.ready = 1'b0;
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 3) : 0;
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        run_kind_t   kind;
        int unsigned run_len;
        int unsigned span;
        int unsigned w;
        int unsigned h;
        bit          tall;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.op          = sfp_pkg::OP_PLACE;
        req_ch.rect_width  = '0;
        req_ch.rect_height = '0;
        usable_width       = 1024;
        random_reqs        = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset width of 1024.
        place(1, 0);            // zero-height shelf
        place(1024, 4096);      // full width, full height, new shelf
        place(1025, 1);         // one past the sheet width
        place(0, 5);            // zero width
        place(10, 4097);        // height past MAX_DIM
        place(8191, 8191);      // all-ones fields
        place(1023, 0);         // fills the zero-height shelf exactly
        place(100, 50);         // no room anywhere, opens a third shelf
        place(200, 30);         // lands beside it
        place(4096, 4096);      // wider than the sheet
        clear_sheet();
        place(1, 1);

        // Register above MAX_DIM saturates.
        set_sheet_width(8191);
        place(4096, 4096);
        place(4096, 4096);
        place(4097, 1);
        place(7, 1);

        // Narrow the sheet with shelves open: the old ones stop fitting.
        set_sheet_width(1);
        place(1, 1);
        place(2, 1);

        // Zero width accepts nothing.
        set_sheet_width(0);
        place(1, 0);

        set_sheet_width(1024);
        clear_sheet();
        place(512, 16);
        place(512, 16);
        place(1, 16);

        // Random part: mostly packing runs, some runs that fill the table to
        // overflow, and some raw noise over the whole field range.
        while (random_reqs < RANDOM_REQS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 6))
                    0:       set_sheet_width(1);
                    1:       set_sheet_width(4096);
                    2:       set_sheet_width(8191);
                    3:       set_sheet_width(1024);
                    4:       set_sheet_width($urandom_range(0, 8191));
                    default: set_sheet_width($urandom_range(1, 4096));
                endcase
            end

            case ($urandom_range(0, 9))
                0:       kind = RUN_FILL;
                1, 2:    kind = RUN_NOISE;
                default: kind = RUN_PACK;
            endcase
            if (kind == RUN_FILL && usable_width == 0)
                kind = RUN_NOISE;

            case (kind)
                RUN_FILL:
                begin
                    // Each rectangle is over half the sheet wide, so every one
                    // opens a shelf until the table is full.
                    tall = ($urandom_range(0, 1) == 1);
                    clear_sheet();
                    random_reqs++;
                    repeat (MAX_SHELVES + $urandom_range(1, 3))
                    begin
                        w = $urandom_range(usable_width / 2 + 1, usable_width);
                        h = tall ? MAX_DIM : $urandom_range(0, MAX_DIM);
                        place(w, h);
                        random_reqs++;
                    end
                end
                RUN_NOISE:
                begin
                    repeat ($urandom_range(1, 10))
                    begin
                        send_request(1'($urandom_range(0, 1)),
                                     sfp_pkg::DIM_W'($urandom_range(0, 8191)),
                                     sfp_pkg::DIM_W'($urandom_range(0, 8191)));
                        random_reqs++;
                    end
                end
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        clear_sheet();
                        random_reqs++;
                    end
                    run_len = $urandom_range(1, 40);
                    // Narrow spans pack many rectangles per shelf.
                    span = usable_width >> (2 * $urandom_range(0, 2));
                    if (span == 0)
                        span = 1;
                    repeat (run_len)
                    begin
                        w = $urandom_range(1, span);
                        h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_DIM)
                                                        : $urandom_range(0, 32);
                        place(w, h);
                        random_reqs++;
                    end
                end
            endcase
        end

        // Drain: drop valid, wait out every pending result, then stay quiet
        // for one full scan so a stray extra beat gets caught.
        req_ch.valid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
